### rtl/core/atcis_pkg.sv
// shared types, constants and command rom for the at command init sequencer
package atcis_pkg;

  // command rom geometry
  localparam int COMMAND_ROM_DEPTH = 128;
  localparam int ROM_AW = $clog2(COMMAND_ROM_DEPTH);
  localparam int CMD_BYTES = 107;

  // longest command is 34 bytes
  localparam int CNT_W = 6;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // step codes
  localparam logic [2:0] STEP_IDLE     = 3'd0;
  localparam logic [2:0] STEP_FIRST    = 3'd1;
  localparam logic [2:0] STEP_LAST_CMD = 3'd5;
  localparam logic [2:0] STEP_FINAL    = 3'd6;
  localparam logic [2:0] STEP_DONE     = 3'd7;

  // reply characters
  localparam logic [7:0] CHAR_O  = 8'h4F;
  localparam logic [7:0] CHAR_K  = 8'h4B;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // command strings, first byte in the top bits
  localparam logic [13*8-1:0] CMD_S1 = {"AT+CWMODE=3", CHAR_CR, CHAR_LF};
  localparam logic [34*8-1:0] CMD_S2 = {
    64'h4154_2B43_574A_4150, 64'h3D22_4D45_4348_4E49,
    64'h4748_5422_2C22_6633, 64'h3364_6261_636B_3522,
    16'h0D0A
  };
  localparam logic [26*8-1:0] CMD_S3 = {"AT+CIPSTA=\"192.168.1.56\"", CHAR_CR, CHAR_LF};
  localparam logic [13*8-1:0] CMD_S4 = {"AT+CIPMUX=1", CHAR_CR, CHAR_LF};
  localparam logic [21*8-1:0] CMD_S5 = {"AT+CIPSERVER=1,1336", CHAR_CR, CHAR_LF};
  localparam logic [CMD_BYTES*8-1:0] CMD_BLOB = {CMD_S1, CMD_S2, CMD_S3, CMD_S4, CMD_S5};

  // work handed from front to back
  typedef struct packed {
    logic       cmd_en;
    logic [2:0] cmd_sel;
    logic [7:0] echo_byte;
    logic       done;
  } job_t;

  typedef enum logic [1:0] {
    BK_START,
    BK_CMD,
    BK_ECHO
  } back_state_e;

  // rom byte, zero past the stored strings
  function automatic logic [7:0] cmd_rom_byte(logic [ROM_AW-1:0] addr);
    logic [7:0] b;
    b = 8'h00;
    if (int'(addr) < CMD_BYTES) begin
      b = CMD_BLOB[(CMD_BYTES - 1 - int'(addr)) * 8 +: 8];
    end
    return b;
  endfunction

  // first rom address of a command
  function automatic logic [ROM_AW-1:0] cmd_start(logic [2:0] sel);
    logic [ROM_AW-1:0] s;
    unique case (sel)
      3'd0:    s = ROM_AW'(0);
      3'd1:    s = ROM_AW'(13);
      3'd2:    s = ROM_AW'(47);
      3'd3:    s = ROM_AW'(73);
      3'd4:    s = ROM_AW'(86);
      default: s = ROM_AW'(0);
    endcase
    return s;
  endfunction

  // byte count of a command
  function automatic logic [CNT_W-1:0] cmd_len(logic [2:0] sel);
    logic [CNT_W-1:0] n;
    unique case (sel)
      3'd0:    n = CNT_W'(13);
      3'd1:    n = CNT_W'(34);
      3'd2:    n = CNT_W'(26);
      3'd3:    n = CNT_W'(13);
      3'd4:    n = CNT_W'(21);
      default: n = CNT_W'(1);
    endcase
    return n;
  endfunction

endpackage

### rtl/core/atcis_front.sv
// front end: tracks step and reply window, turns each beat into a job
module atcis_front
  import atcis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_error_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic       active_q, active_d;
  logic [2:0] step_q, step_d;
  logic [7:0] hist_q [3];
  logic [7:0] hist_d [3];
  logic       accept;
  logic       matched;
  logic       in_range;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (step_q >= STEP_FIRST) && (step_q <= STEP_FINAL);
  assign matched    = (rx_byte_i == CHAR_LF) && (hist_q[0] == CHAR_CR) &&
                      (hist_q[1] == CHAR_K) && (hist_q[2] == CHAR_O);

  // classify the beat and update the sequencer state
  always_comb begin
    active_d   = active_q;
    step_d     = step_q;
    hist_d     = hist_q;
    push_o     = 1'b0;
    job_o      = '0;
    if (accept) begin
      priority if (action_i) begin
        active_d = 1'b1;
        step_d   = STEP_FIRST;
        hist_d   = '{8'h00, 8'h00, 8'h00};
      end else if (!rx_error_i && active_q) begin
        push_o          = 1'b1;
        job_o.echo_byte = rx_byte_i;
        if (in_range) begin
          if (matched) begin
            hist_d = '{8'h00, 8'h00, 8'h00};
            if (step_q <= STEP_LAST_CMD) begin
              job_o.cmd_en  = 1'b1;
              job_o.cmd_sel = step_q - STEP_FIRST;
              step_d        = step_q + 3'd1;
            end else begin
              step_d   = STEP_DONE;
              active_d = 1'b0;
            end
          end else begin
            hist_d[2] = hist_q[1];
            hist_d[1] = hist_q[0];
            hist_d[0] = rx_byte_i;
          end
        end
        job_o.done = (step_d == STEP_DONE);
      end else begin
        // error beat or byte while idle: dropped
        push_o = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= STEP_IDLE;
      hist_q   <= '{8'h00, 8'h00, 8'h00};
    end else begin
      active_q <= active_d;
      step_q   <= step_d;
      hist_q   <= hist_d;
    end
  end

endmodule

### rtl/core/atcis_queue.sv
// short job queue between front and back
module atcis_queue
  import atcis_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    n = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    return n;
  endfunction

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/atcis_back.sv
// back end: expands a job into command bytes and the echo byte
module atcis_back
  import atcis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       last_of_run_o,
  output logic       sequence_done_o
);

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        tx_byte_q, byte_d;
  logic              last_q, last_d;
  logic              done_q;
  logic              can_load;
  logic              emit;
  logic [ROM_AW-1:0] start;
  logic [CNT_W-1:0]  len;
  logic [7:0]        rom_byte;

  assign can_load = !out_valid_q || out_ready_i;
  assign start    = cmd_start(job_i.cmd_sel);
  assign len      = cmd_len(job_i.cmd_sel);
  assign rom_byte = cmd_rom_byte(start + ROM_AW'(cnt_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_START: begin
        if (job_valid_i && can_load && job_i.cmd_en) begin
          state_d = (len == CNT_W'(1)) ? BK_ECHO : BK_CMD;
        end
      end
      BK_CMD: begin
        if (can_load && (cnt_q == len - CNT_W'(1))) state_d = BK_ECHO;
      end
      BK_ECHO: begin
        if (can_load) state_d = BK_START;
      end
      default: state_d = BK_START;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit   = 1'b0;
    pop_o  = 1'b0;
    cnt_d  = cnt_q;
    byte_d = job_i.echo_byte;
    last_d = 1'b1;
    unique case (state_q)
      BK_START: begin
        if (job_valid_i && can_load) begin
          emit = 1'b1;
          if (job_i.cmd_en) begin
            byte_d = rom_byte;
            last_d = 1'b0;
            cnt_d  = CNT_W'(1);
          end else begin
            pop_o = 1'b1;
          end
        end
      end
      BK_CMD: begin
        if (can_load) begin
          emit   = 1'b1;
          byte_d = rom_byte;
          last_d = 1'b0;
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      BK_ECHO: begin
        if (can_load) begin
          emit  = 1'b1;
          pop_o = 1'b1;
          cnt_d = '0;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_START;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      tx_byte_q <= byte_d;
      last_q    <= last_d;
      done_q    <= job_i.done;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tx_byte_o       = tx_byte_q;
  assign last_of_run_o   = last_q;
  assign sequence_done_o = done_q;

  // a job leaves the queue only together with its echo beat
  a_pop_with_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (emit && last_d))
    else $error("job popped without its echo beat");

  // the head job stays in place while its command runs
  a_cmd_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CMD || state_q == BK_ECHO) |-> job_valid_i)
    else $error("command phase without a job at the queue head");

  // only command jobs reach the command phase
  a_cmd_is_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CMD) |-> job_i.cmd_en)
    else $error("command phase for an echo-only job");

  // a held beat is not overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit)
    else $error("output beat overwritten while stalled");

endmodule

### rtl/core/at_command_init_sequencer.sv
// top level of the at command init sequencer
//
// Input channel (in_valid_i/in_ready_o): one beat per received uart byte
// with its error flag, or a start action that arms the sequencer at step
// one. Output channel (out_valid_o/out_ready_i): transmit bytes, a fixed
// command string from the rom when the reply "OK\r\n" completes in steps
// one to five, then the echo of every good byte received while armed.
// last_of_run_o marks the final byte caused by one input beat.
// The first output byte of an input beat passes through the job queue and
// then the output beat register.
// Throughput: the front takes one beat per cycle while the two-entry job
// queue has room; the back emits one byte per cycle while the receiver is
// ready, through the single output beat register.
// Reset clears the step, the reply window, the queue and the output valid
// flag. When the receiver stalls, the output beat holds, the back stops,
// the queue fills and then in_ready_o drops.
module at_command_init_sequencer
  import atcis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_error_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       last_of_run_o,
  output logic       sequence_done_o
);

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  atcis_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .rx_byte_i  (rx_byte_i),
    .rx_error_i (rx_error_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  atcis_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_job)
  );

  atcis_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (head_valid),
    .job_i           (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_byte_o       (tx_byte_o),
    .last_of_run_o   (last_of_run_o),
    .sequence_done_o (sequence_done_o)
  );

endmodule

### test/tb_at_command_init_sequencer.sv
// self-checking testbench for the at command init sequencer with random stalls on both sides
module tb_at_command_init_sequencer;
  import atcis_pkg::*;

  // steps that carry a command but have no name in the package
  localparam logic [2:0] STEP_JOIN = 3'd2;
  localparam logic [2:0] STEP_ADDR = 3'd3;
  localparam logic [2:0] STEP_MUX  = 3'd4;

  localparam int RANDOM_ITEMS = 135;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS   = 20;

  typedef logic [7:0] byte_q_t [$];

  typedef struct {
    logic       action;
    logic [7:0] rx;
    logic       err;
  } rx_item_t;

  typedef struct {
    logic [7:0] tx;
    logic       last;
    logic       done;
  } tx_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       action_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       rx_error_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] tx_byte_o;
  logic       last_of_run_o;
  logic       sequence_done_o;

  at_command_init_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .rx_byte_i      (rx_byte_i),
    .rx_error_i     (rx_error_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tx_byte_o      (tx_byte_o),
    .last_of_run_o  (last_of_run_o),
    .sequence_done_o(sequence_done_o)
  );

  always #1 clk_i = ~clk_i;

  // pending receive beats and predicted transmit bytes
  rx_item_t rx_pending [$];
  tx_beat_t tx_expect [$];

  // predictor state
  logic       seq_armed = 1'b0;
  logic [2:0] seq_step = STEP_IDLE;
  logic [7:0] reply_win [3] = '{8'h00, 8'h00, 8'h00};

  int  stim_weight = 0;
  int  total_items = 0;
  int  beats_in = 0;
  int  starts_in = 0;
  int  beats_out = 0;
  int  sessions_done = 0;
  int  err_count = 0;
  bit  in_acc = 1'b0;
  bit  out_acc = 1'b0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;

  // one mismatch line, printing capped
  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("mismatch on output beat %0d: %s got %0h want %0h", beats_out, what, got, want);
    err_count++;
  endtask

  // stall length per beat, with runs of back-to-back beats
  function automatic int unsigned pick_wait(inout bit calm);
    if ($urandom_range(0, 24) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // command string sent when the reply of a given step completes
  function automatic byte_q_t command_bytes(input logic [2:0] st);
    byte_q_t q;
    string s;
    logic [255:0] join_hex;
    // join-network command, kept in hex
    join_hex = {64'h4154_2B43_574A_4150, 64'h3D22_4D45_4348_4E49,
                64'h4748_5422_2C22_6633, 64'h3364_6261_636B_3522};
    s = "";
    case (st)
      STEP_FIRST:    s = "AT+CWMODE=3";
      STEP_ADDR:     s = "AT+CIPSTA=\"192.168.1.56\"";
      STEP_MUX:      s = "AT+CIPMUX=1";
      STEP_LAST_CMD: s = "AT+CIPSERVER=1,1336";
      default:       s = "";
    endcase
    if (st == STEP_JOIN) begin
      for (int i = 0; i < 32; i++) q.push_back(join_hex[(31 - i) * 8 +: 8]);
    end else begin
      for (int i = 0; i < s.len(); i++) q.push_back(8'(s[i]));
    end
    if (q.size() != 0) begin
      q.push_back(CHAR_CR);
      q.push_back(CHAR_LF);
    end
    return q;
  endfunction

  // work out the transmit bytes caused by one receive beat
  task automatic predict_tx(input logic act, input logic [7:0] b, input logic err);
    byte_q_t run;
    logic hit;
    if (act) begin
      seq_armed = 1'b1;
      seq_step = STEP_FIRST;
      foreach (reply_win[i]) reply_win[i] = 8'h00;
      return;
    end
    if (err || !seq_armed) return;
    if (seq_step >= STEP_FIRST && seq_step <= STEP_FINAL) begin
      hit = (b == CHAR_LF) && (reply_win[0] == CHAR_CR) &&
            (reply_win[1] == CHAR_K) && (reply_win[2] == CHAR_O);
      if (hit) begin
        if (seq_step <= STEP_LAST_CMD) begin
          run = command_bytes(seq_step);
          seq_step = seq_step + 3'd1;
        end else begin
          seq_step = STEP_DONE;
          seq_armed = 1'b0;
          sessions_done++;
        end
        foreach (reply_win[i]) reply_win[i] = 8'h00;
      end else begin
        reply_win[2] = reply_win[1];
        reply_win[1] = reply_win[0];
        reply_win[0] = b;
      end
    end
    run.push_back(b);
    foreach (run[i])
      tx_expect.push_back('{tx: run[i], last: (i == run.size() - 1),
                            done: (seq_step == STEP_DONE)});
  endtask

  // stimulus helpers
  task automatic push_item(input logic act, input logic [7:0] b, input logic err);
    rx_pending.push_back('{action: act, rx: b, err: err});
    if (act || !err) stim_weight++;
  endtask

  task automatic push_reply(input bit noisy);
    logic [7:0] txt [4];
    txt = '{CHAR_O, CHAR_K, CHAR_CR, CHAR_LF};
    foreach (txt[i]) begin
      if (noisy && $urandom_range(0, 5) == 0)
        push_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
      push_item(1'b0, txt[i], 1'b0);
    end
  endtask

  // receive-side driver
  always @(negedge clk_i) begin
    rx_item_t cur;
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if (in_wait != 0) begin
        in_valid_i <= 1'b0;
        in_wait <= in_wait - 1;
      end else if (rx_pending.size() != 0) begin
        cur = rx_pending.pop_front();
        in_valid_i <= 1'b1;
        action_i <= cur.action;
        rx_byte_i <= cur.rx;
        rx_error_i <= cur.err;
        in_wait <= pick_wait(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // transmit-side ready with random stalls
  always @(negedge clk_i) begin
    int unsigned w;
    if (rst_ni) begin
      if (out_acc) begin
        w = pick_wait(out_calm);
        out_ready_i <= (w == 0);
        out_wait <= (w == 0) ? 0 : w - 1;
      end else if (out_wait != 0) begin
        out_ready_i <= 1'b0;
        out_wait <= out_wait - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted receive beats, check transmit beats
  always @(posedge clk_i) begin
    tx_beat_t want;
    if (!rst_ni) begin
      in_acc <= 1'b0;
      out_acc <= 1'b0;
    end else begin
      in_acc <= in_valid_i && in_ready_o;
      out_acc <= out_valid_o && out_ready_i;
      if (in_valid_i && in_ready_o) begin
        beats_in++;
        if (action_i) starts_in++;
        predict_tx(action_i, rx_byte_i, rx_error_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (tx_expect.size() == 0) begin
          report_mismatch("byte with nothing pending, tx_byte", tx_byte_o, 0);
        end else begin
          want = tx_expect.pop_front();
          if (tx_byte_o !== want.tx) report_mismatch("tx_byte", tx_byte_o, want.tx);
          if (last_of_run_o !== want.last)
            report_mismatch("last_of_run", last_of_run_o, want.last);
          if (sequence_done_o !== want.done)
            report_mismatch("sequence_done", sequence_done_o, want.done);
        end
        beats_out++;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int target;
    int n;
    // directed: extremes, dropped error byte inside a reply, all six replies
    push_item(1'b0, 8'hFF, 1'b0);
    push_item(1'b1, 8'hFF, 1'b1);
    push_item(1'b0, 8'hFF, 1'b0);
    push_item(1'b0, 8'h00, 1'b0);
    push_item(1'b0, CHAR_O, 1'b0);
    push_item(1'b0, CHAR_K, 1'b0);
    push_item(1'b0, CHAR_LF, 1'b1);
    push_item(1'b0, CHAR_CR, 1'b0);
    push_item(1'b0, CHAR_LF, 1'b0);
    repeat (5) push_reply(1'b0);
    push_item(1'b0, 8'h5A, 1'b0);

    // random: mostly complete sessions with noise, some raw noise
    target = RANDOM_ITEMS;
    while (stim_weight < target) begin
      if ($urandom_range(0, 9) < 7) begin
        push_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        for (int st = 1; st <= 6; st++) begin
          n = $urandom_range(0, 3);
          repeat (n)
            push_item(1'b0, 8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
          // broken reply
          if ($urandom_range(0, 11) == 0) begin
            push_item(1'b0, CHAR_O, 1'b0);
            push_item(1'b0, CHAR_K, 1'b0);
            push_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
          end
          // abandoned session, the next start rearms
          if ($urandom_range(0, 14) == 0) break;
          push_reply(1'b1);
        end
        repeat ($urandom_range(0, 2))
          push_item(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(3, 10)) begin
          if ($urandom_range(0, 11) == 0)
            push_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          else if ($urandom_range(0, 2) == 0)
            push_item(1'b0, (($urandom_range(0, 1) == 0) ?
                             (($urandom_range(0, 1) == 0) ? CHAR_O : CHAR_K) :
                             (($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF)),
                      ($urandom_range(0, 5) == 0));
          else
            push_item(1'b0, 8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
        end
      end
    end
    total_items = rx_pending.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (beats_in != total_items) @(negedge clk_i);
    while (tx_expect.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run covered %0d receive beats (%0d starts) and %0d transmit bytes,",
             beats_in, starts_in, beats_out);
    $display("with %0d init sequences carried through to the final reply", sessions_done);
    if (err_count == 0) begin
      $display("[at_command_init_sequencer] OK");
    end else begin
      $display("[at_command_init_sequencer] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timed out with %0d of %0d receive beats taken, %0d bytes outstanding",
             beats_in, total_items, tx_expect.size());
    $display("[at_command_init_sequencer] ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/core/atcis_pkg.sv
rtl/core/atcis_front.sv
rtl/core/atcis_queue.sv
rtl/core/atcis_back.sv
rtl/core/at_command_init_sequencer.sv
test/tb_at_command_init_sequencer.sv
